@@ hdl/deque_with_indexed_remove_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the deque with indexed removal
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DEQUE_WITH_INDEXED_REMOVE_TOP_DEFINES_SVH
`define DEQUE_WITH_INDEXED_REMOVE_TOP_DEFINES_SVH

// Same-cycle implication
`define DWIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DWIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/dwir_pkg.sv @@
// ---------------------------------------------------------------------------
// dwir_pkg
// Types and constants for the deque with indexed removal.
// ---------------------------------------------------------------------------
package dwir_pkg;

  localparam int CAPACITY      = 16;
  localparam int PAYLOAD_WIDTH = 32;

  // Field widths on the stream ports
  localparam int CMD_W  = 2;
  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // Internal widths
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int EXT_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_PREPEND = 2'd1,
    CMD_POP     = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Shift operation broadcast along the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUT_BACK,
    OP_PUT_FRONT,
    OP_TAKE
  } chain_op_t;

  typedef struct packed {
    chain_op_t                op;
    logic [IDX_W-1:0]         idx;
    logic [PAYLOAD_WIDTH-1:0] word;
  } chain_ctl_t;

  typedef struct packed {
    status_t          status;
    logic             take;
    logic [CNT_W-1:0] count_next;
  } item_res_t;

endpackage

@@ hdl/dwir_cell.sv @@
// ---------------------------------------------------------------------------
// dwir_cell
// One slot of the entry chain: holds, loads, or takes a neighbour's word.
// ---------------------------------------------------------------------------
module dwir_cell (
  input  logic                                 clk,
  input  dwir_pkg::chain_ctl_t                 ctl,
  input  logic [dwir_pkg::IDX_W-1:0]           slot,
  input  logic [dwir_pkg::PAYLOAD_WIDTH-1:0]   prev_data,
  input  logic [dwir_pkg::PAYLOAD_WIDTH-1:0]   next_data,
  output logic [dwir_pkg::PAYLOAD_WIDTH-1:0]   data
);

  logic [dwir_pkg::PAYLOAD_WIDTH-1:0] data_next;

  // slot update per broadcast operation
  always_comb begin
    data_next = data;
    case (ctl.op)
      dwir_pkg::OP_HOLD: begin
        data_next = data;
      end
      dwir_pkg::OP_PUT_BACK: begin
        if (slot == ctl.idx) data_next = ctl.word;
      end
      dwir_pkg::OP_PUT_FRONT: begin
        // front slot takes the new word, the rest move one place back
        data_next = (slot == '0) ? ctl.word : prev_data;
      end
      dwir_pkg::OP_TAKE: begin
        // slots at and behind the gap close up
        if (slot >= ctl.idx) data_next = next_data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ hdl/dwir_ctrl.sv @@
// ---------------------------------------------------------------------------
// dwir_ctrl
// Command decode: bounds checks, index mapping and chain operation.
// ---------------------------------------------------------------------------
module dwir_ctrl (
  input  logic                              accept,
  input  logic [dwir_pkg::CMD_W-1:0]        command,
  input  logic [dwir_pkg::WORD_W-1:0]       payload,
  input  logic [dwir_pkg::POS_W-1:0]        position,
  input  logic [dwir_pkg::CNT_W-1:0]        count,
  output dwir_pkg::chain_ctl_t              ctl,
  output dwir_pkg::item_res_t               res
);

  logic signed [dwir_pkg::EXT_W-1:0] cnt_ext;
  logic signed [dwir_pkg::EXT_W-1:0] pos_ext;
  logic signed [dwir_pkg::EXT_W-1:0] eff;
  logic                              in_range;
  logic                              full;
  logic                              empty;
  logic [dwir_pkg::CNT_W-1:0]        last;

  // effective index: negative positions count from the back
  always_comb begin
    cnt_ext  = dwir_pkg::EXT_W'(count);
    pos_ext  = {{(dwir_pkg::EXT_W - dwir_pkg::POS_W){position[dwir_pkg::POS_W-1]}}, position};
    eff      = position[dwir_pkg::POS_W-1] ? (cnt_ext + pos_ext) : pos_ext;
    in_range = !eff[dwir_pkg::EXT_W-1] && (eff < cnt_ext);
    full     = (count == dwir_pkg::CNT_W'(dwir_pkg::CAPACITY));
    empty    = (count == '0);
    last     = count - dwir_pkg::CNT_W'(1);
  end

  // chain operation and item status
  always_comb begin
    ctl.op         = dwir_pkg::OP_HOLD;
    ctl.idx        = count[dwir_pkg::IDX_W-1:0];
    ctl.word       = dwir_pkg::PAYLOAD_WIDTH'(payload);
    res.status     = dwir_pkg::ST_OK;
    res.take       = 1'b0;
    res.count_next = count;
    case (dwir_pkg::cmd_t'(command))
      dwir_pkg::CMD_APPEND: begin
        if (full) begin
          res.status = dwir_pkg::ST_FULL;
        end else begin
          ctl.op         = dwir_pkg::OP_PUT_BACK;
          res.count_next = count + dwir_pkg::CNT_W'(1);
        end
      end
      dwir_pkg::CMD_PREPEND: begin
        if (full) begin
          res.status = dwir_pkg::ST_FULL;
        end else begin
          ctl.op         = dwir_pkg::OP_PUT_FRONT;
          res.count_next = count + dwir_pkg::CNT_W'(1);
        end
      end
      dwir_pkg::CMD_POP: begin
        ctl.idx = last[dwir_pkg::IDX_W-1:0];
        if (empty) begin
          res.status = dwir_pkg::ST_EMPTY;
        end else begin
          ctl.op         = dwir_pkg::OP_TAKE;
          res.take       = 1'b1;
          res.count_next = last;
        end
      end
      dwir_pkg::CMD_REMOVE: begin
        ctl.idx = eff[dwir_pkg::IDX_W-1:0];
        if (!in_range) begin
          res.status = dwir_pkg::ST_EMPTY;
        end else begin
          ctl.op         = dwir_pkg::OP_TAKE;
          res.take       = 1'b1;
          res.count_next = last;
        end
      end
      default: begin
        ctl.op = dwir_pkg::OP_HOLD;
      end
    endcase
    // nothing moves without an accepted item
    if (!accept) ctl.op = dwir_pkg::OP_HOLD;
  end

endmodule

@@ hdl/deque_with_indexed_remove_top.sv @@
// ---------------------------------------------------------------------------
// deque_with_indexed_remove_top
// Bounded deque of payload words with append, prepend, pop and indexed remove.
// ---------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream: a command, a payload word for inserts and a
//   signed position for indexed removal (negative counts from the back).
//   Each item yields exactly one result on the m_ stream: the word taken out
//   (zero if none), a status (ok, empty/out of range, full) and the new
//   occupancy.
//   Entries sit in a row of cells; a prepend or a removal shifts the cells at
//   or behind its slot at once, and an append writes only the back slot.
//   The result is registered and appears in the cycle after acceptance.
//   Throughput is one item per cycle while the receiver takes each result.
//   A new item is taken while a result waits only if that result is being
//   taken in the same cycle; a stalled receiver holds the result and stops
//   input until it is taken.
//   Reset empties the store (occupancy zero) and drops any pending result;
//   cell contents are not cleared and are never read before being written.
// ---------------------------------------------------------------------------
`include "deque_with_indexed_remove_top_defines.svh"

module deque_with_indexed_remove_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // command[1:0], payload[33:2], position[38:34], pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // removed_payload[31:0], status[33:32], occupancy[38:34], pad
);

  localparam int PW = dwir_pkg::PAYLOAD_WIDTH;

  logic                           accept;
  logic [dwir_pkg::CNT_W-1:0]     count;
  dwir_pkg::chain_ctl_t           ctl;
  dwir_pkg::item_res_t            res;
  logic [PW-1:0]                  cell_data [dwir_pkg::CAPACITY];
  logic [dwir_pkg::WORD_W-1:0]    removed;
  logic [dwir_pkg::WORD_W-1:0]    out_removed;
  dwir_pkg::status_t              out_status;
  logic [dwir_pkg::OCC_W-1:0]     out_occ;

  // handshake; no item is taken during reset
  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // command decode
  dwir_ctrl u_ctrl (
    .accept   (accept),
    .command  (s_tdata[1:0]),
    .payload  (s_tdata[33:2]),
    .position (s_tdata[38:34]),
    .count    (count),
    .ctl      (ctl),
    .res      (res)
  );

  // chain of entry cells
  for (genvar i = 0; i < dwir_pkg::CAPACITY; i++) begin : g_cell
    localparam int PI = (i == 0) ? 0 : i - 1;
    localparam int NI = (i == dwir_pkg::CAPACITY - 1) ? i : i + 1;
    dwir_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .slot      (dwir_pkg::IDX_W'(i)),
      .prev_data (cell_data[PI]),
      .next_data (cell_data[NI]),
      .data      (cell_data[i])
    );
  end

  // word leaving the chain
  assign removed = res.take ? dwir_pkg::WORD_W'(cell_data[ctl.idx]) : '0;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= res.count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_removed <= removed;
      out_status  <= res.status;
      out_occ     <= dwir_pkg::OCC_W'(res.count_next);
    end
  end

  assign m_tdata = {1'b0, out_occ, out_status, out_removed};

  // checks
  `DWIR_ASSERT_NOW(a_count_bound, 1'b1, count <= dwir_pkg::CNT_W'(dwir_pkg::CAPACITY), "occupancy above capacity")
  `DWIR_ASSERT_NEXT(a_result_follows, accept, m_tvalid, "no result after accepted item")
  `DWIR_ASSERT_NEXT(a_count_stable, !accept, $stable(count), "occupancy moved without an item")
  `DWIR_ASSERT_NOW(a_full_status, m_tvalid && (out_status == dwir_pkg::ST_FULL), out_occ == dwir_pkg::OCC_W'(dwir_pkg::CAPACITY), "full status below capacity")

endmodule

@@ tb/sv/deque_with_indexed_remove_top_tb.sv @@
// ---------------------------------------------------------------------------
// deque_with_indexed_remove_top_tb
// Self-checking bench for the deque with indexed removal. A shadow deque
// predicts the taken word, status and occupancy of every accepted item.
// Directed items cover the empty, full and out-of-range cases first. Random
// phases then drift the fill level up and down, with bursts of idling on
// both streams and a long receiver hold-off that stalls the input.
// ---------------------------------------------------------------------------
module deque_with_indexed_remove_top_tb;

  localparam int RUN_LIMIT    = 400000;
  localparam int PHASE_ITEMS  = 250;
  localparam int NUM_PHASES   = 6;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 8;

  // One predicted result
  typedef struct {
    logic [dwir_pkg::WORD_W-1:0] word;
    dwir_pkg::status_t           status;
    logic [dwir_pkg::OCC_W-1:0]  occ;
  } deque_result_t;

  // Shadow deque and queue of results still to arrive
  class deque_scoreboard;
    logic [dwir_pkg::WORD_W-1:0] entries[$];
    deque_result_t               awaited[$];
    int                          errors;

    function int occupancy();
      return entries.size();
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Apply one accepted item to the shadow deque and queue its result
    function void note_item(dwir_pkg::cmd_t cmd, logic [dwir_pkg::WORD_W-1:0] word,
                            logic signed [dwir_pkg::POS_W-1:0] pos);
      deque_result_t r;
      int idx;
      r.word   = '0;
      r.status = dwir_pkg::ST_OK;
      case (cmd)
        dwir_pkg::CMD_APPEND, dwir_pkg::CMD_PREPEND: begin
          if (entries.size() >= dwir_pkg::CAPACITY) r.status = dwir_pkg::ST_FULL;
          else if (cmd == dwir_pkg::CMD_APPEND) entries.push_back(word);
          else entries.push_front(word);
        end
        dwir_pkg::CMD_POP: begin
          if (entries.size() == 0) r.status = dwir_pkg::ST_EMPTY;
          else r.word = entries.pop_back();
        end
        default: begin
          // negative position counts from the back
          idx = int'(pos);
          if (idx < 0) idx += entries.size();
          if (idx < 0 || idx >= entries.size()) begin
            r.status = dwir_pkg::ST_EMPTY;
          end else begin
            r.word = entries[idx];
            entries.delete(idx);
          end
        end
      endcase
      r.occ = dwir_pkg::OCC_W'(entries.size());
      awaited.push_back(r);
    endfunction

    // Compare one result with the oldest prediction
    task check_result(logic [39:0] data);
      deque_result_t r;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result %h", data));
      end else begin
        r = awaited.pop_front();
        if (data[31:0] !== r.word)
          report($sformatf("word %h, predicted %h", data[31:0], r.word));
        if (data[33:32] !== r.status)
          report($sformatf("status %0d, predicted %0d", data[33:32], r.status));
        if (data[38:34] !== r.occ)
          report($sformatf("occupancy %0d, predicted %0d", data[38:34], r.occ));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // command[1:0], payload[33:2], position[38:34], pad
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // removed_payload[31:0], status[33:32], occupancy[38:34], pad

  deque_scoreboard sb;
  bit              idling;
  bit              long_hold_req;
  int              cycle_count;

  deque_with_indexed_remove_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sample both streams at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready)
        sb.note_item(dwir_pkg::cmd_t'(s_tdata[1:0]), s_tdata[33:2], s_tdata[38:34]);
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // Offer one item from a falling edge until it is accepted
  task automatic drive_item(dwir_pkg::cmd_t cmd, logic [dwir_pkg::WORD_W-1:0] word,
                            logic [dwir_pkg::POS_W-1:0] pos);
    if (idling && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, pos, word, cmd};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Random item steered by the current fill level; insert_pct sets the drift
  task automatic drive_random_item(int insert_pct);
    int                         n;
    int                         k;
    dwir_pkg::cmd_t             cmd;
    logic [dwir_pkg::POS_W-1:0] pos;
    n   = sb.occupancy();
    pos = dwir_pkg::POS_W'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      // noise: any command, any position
      cmd = dwir_pkg::cmd_t'($urandom_range(0, 3));
    end else if ($urandom_range(0, 99) < insert_pct) begin
      cmd = $urandom_range(0, 1) ? dwir_pkg::CMD_APPEND : dwir_pkg::CMD_PREPEND;
    end else if ($urandom_range(0, 9) < 3) begin
      cmd = dwir_pkg::CMD_POP;
    end else begin
      cmd = dwir_pkg::CMD_REMOVE;
      if (n > 0 && $urandom_range(0, 99) < 85) begin
        k   = $urandom_range(0, n - 1);
        pos = $urandom_range(0, 1) ? dwir_pkg::POS_W'(k) : dwir_pkg::POS_W'(k - n);
      end
    end
    drive_item(cmd, $urandom, pos);
  endtask

  // Stimulus
  initial begin
    int bias[NUM_PHASES];
    sb            = new();
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    idling        = 1'b1;
    long_hold_req = 1'b0;
    bias          = '{75, 25, 50, 80, 20, 50};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty store: pop and removals all fail
    drive_item(dwir_pkg::CMD_POP, 32'h0, 5'd0);
    drive_item(dwir_pkg::CMD_REMOVE, 32'h0, 5'd0);
    drive_item(dwir_pkg::CMD_REMOVE, 32'h0, 5'b10000);
    // Fill to capacity with extreme and random words
    drive_item(dwir_pkg::CMD_APPEND, 32'hFFFF_FFFF, 5'd0);
    drive_item(dwir_pkg::CMD_PREPEND, 32'h0, 5'd0);
    for (int i = 0; i < dwir_pkg::CAPACITY - 2; i++)
      drive_item((i % 2) ? dwir_pkg::CMD_PREPEND : dwir_pkg::CMD_APPEND, $urandom, 5'd0);
    // Inserts when full
    drive_item(dwir_pkg::CMD_APPEND, 32'hA5A5_A5A5, 5'd0);
    drive_item(dwir_pkg::CMD_PREPEND, 32'h5A5A_5A5A, 5'd0);
    // Removal at the back end, at the second slot by a negative position, then at the front and the back end
    drive_item(dwir_pkg::CMD_REMOVE, 32'h0, 5'd15);
    drive_item(dwir_pkg::CMD_REMOVE, 32'h0, -5'sd14);
    drive_item(dwir_pkg::CMD_REMOVE, 32'h0, 5'd0);
    drive_item(dwir_pkg::CMD_REMOVE, 32'h0, -5'sd1);
    // Out of range with a part-filled store
    drive_item(dwir_pkg::CMD_REMOVE, 32'h0, 5'd15);
    drive_item(dwir_pkg::CMD_REMOVE, 32'h0, 5'b10000);
    drive_item(dwir_pkg::CMD_POP, 32'h0, 5'd0);

    // Random phases; no idling in the middle stretch and the last part
    for (int p = 0; p < NUM_PHASES; p++) begin
      idling = (p < 2) || (p == 3);
      if (p == 1 || p == 3) long_hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) drive_random_item(bias[p]);
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/dwir_pkg.sv
hdl/dwir_cell.sv
hdl/dwir_ctrl.sv
hdl/deque_with_indexed_remove_top.sv
tb/sv/deque_with_indexed_remove_top_tb.sv
